// ===== hdl/dpcc_pkg.sv =====
// Package for the dual-polarisation cross-correlator core.
// Holds the payload and command types and the shared constants.
// It has no dependencies.
package dpcc_pkg;

   localparam int SAMPLE_BITS   = 8;
   localparam int ACC_BITS_DEF  = 40;
   localparam int NORM_BITS     = 32;
   localparam int VIS_BITS      = 56;
   localparam int CSR_ADDR_BITS = 3;
   localparam int SEL_BITS      = 3;

   localparam logic [NORM_BITS-1:0] NORM_RESET = 32'h0001_0000;
   localparam logic [1:0]           PAIR_LAST  = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] a_pol0_re;
      logic signed [SAMPLE_BITS-1:0] a_pol0_im;
      logic signed [SAMPLE_BITS-1:0] a_pol1_re;
      logic signed [SAMPLE_BITS-1:0] a_pol1_im;
      logic signed [SAMPLE_BITS-1:0] b_pol0_re;
      logic signed [SAMPLE_BITS-1:0] b_pol0_im;
      logic signed [SAMPLE_BITS-1:0] b_pol1_re;
      logic signed [SAMPLE_BITS-1:0] b_pol1_im;
      logic                          final_sample;
   } req_type;

   typedef struct packed {
      logic [1:0]                 pol_pair;
      logic signed [VIS_BITS-1:0] vis_re;
      logic signed [VIS_BITS-1:0] vis_im;
      logic                       run_end;
   } rsp_type;

   // sel: {pair index, component}; component 0 is real, 1 is imaginary
   typedef struct packed {
      logic                mac_en;
      logic                mul_lo;
      logic                mul_hi;
      logic                fin;
      logic                load;
      logic                clear;
      logic [SEL_BITS-1:0] sel;
   } cmd_type;

endpackage

// ===== hdl/dpcc_ctrl.sv =====
// Controller of the cross-correlator: accumulate, flush, scale sequence
// and the result register's valid flag. Drives the datapath through
// dpcc_pkg::cmd_type; depends on dpcc_pkg.
module dpcc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_final,
   output logic              req_stall,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output dpcc_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_ACC   = 3'd0;
   localparam logic [2:0] ST_FLUSH = 3'd1;
   localparam logic [2:0] ST_LO    = 3'd2;
   localparam logic [2:0] ST_HI    = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;
   localparam logic [2:0] ST_LOAD  = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [dpcc_pkg::SEL_BITS-1:0] sel_ff, sel_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          accept;
   logic                          out_free;

   assign req_stall = (state_ff != ST_ACC);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && (state_ff == ST_ACC);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.sel      = sel_ff;
      cmd.mac_en   = accept;
      case (state_ff)
         ST_ACC: begin
            if (accept && req_final) state_in = ST_FLUSH;
         end
         // last product pair still going into the accumulators
         ST_FLUSH: state_in = ST_LO;
         ST_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_HI;
         end
         ST_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin = 1'b1;
            if (sel_ff[0] == 1'b0) begin
               sel_in   = sel_ff + 1'b1;
               state_in = ST_LO;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (sel_ff[2:1] == dpcc_pkg::PAIR_LAST) begin
                  cmd.clear = 1'b1;
                  sel_in    = '0;
                  state_in  = ST_ACC;
               end else begin
                  sel_in   = sel_ff + 1'b1;
                  state_in = ST_LO;
               end
            end
         end
         default: state_in = ST_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/dpcc_datapath.sv =====
// Datapath of the cross-correlator: product stage, saturating
// accumulators, split-multiply scaler and result register.
// Commanded by dpcc_ctrl; depends on dpcc_pkg.
module dpcc_datapath #(
   parameter int ACC_BITS = dpcc_pkg::ACC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dpcc_pkg::cmd_type                cmd,
   input  dpcc_pkg::req_type                req_data,
   input  logic [dpcc_pkg::NORM_BITS-1:0]   norm_scale,
   output dpcc_pkg::rsp_type                rsp_data
);

   localparam int SB        = dpcc_pkg::SAMPLE_BITS;
   localparam int NB        = dpcc_pkg::NORM_BITS;
   localparam int VB        = dpcc_pkg::VIS_BITS;
   localparam int PROD_BITS = 2 * SB + 1;
   localparam int HALF      = (ACC_BITS + 1) / 2;
   localparam int HI_BITS   = ACC_BITS - HALF;
   localparam int LO_P_BITS = HALF + NB;
   localparam int HI_P_BITS = HI_BITS + NB;
   localparam int P_BITS    = ACC_BITS + NB;

   localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam logic [P_BITS-1:0]   LIM_POS =
      {{(P_BITS-VB+1){1'b0}}, {(VB-1){1'b1}}};
   localparam logic [P_BITS-1:0]   LIM_NEG = LIM_POS + 1'b1;

   function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0]  a,
                                                   input logic [PROD_BITS-1:0] b);
      logic [ACC_BITS:0] s;
      s = {a[ACC_BITS-1], a} + {{(ACC_BITS+1-PROD_BITS){b[PROD_BITS-1]}}, b};
      if (s[ACC_BITS] != s[ACC_BITS-1]) sat_add = s[ACC_BITS] ? ACC_MIN : ACC_MAX;
      else sat_add = s[ACC_BITS-1:0];
   endfunction

   logic signed [SB-1:0] ar [2];
   logic signed [SB-1:0] ai [2];
   logic signed [SB-1:0] br [2];
   logic signed [SB-1:0] bi [2];

   logic [PROD_BITS-1:0] prod_re [4];
   logic [PROD_BITS-1:0] prod_im [4];
   logic [PROD_BITS-1:0] p1_re_ff [4];
   logic [PROD_BITS-1:0] p1_im_ff [4];
   logic                 p1_valid_ff;

   logic [ACC_BITS-1:0]  acc_re_ff [4];
   logic [ACC_BITS-1:0]  acc_im_ff [4];

   logic [ACC_BITS-1:0]  acc_sel;
   logic                 neg;
   logic [ACC_BITS-1:0]  mag;
   logic [LO_P_BITS-1:0] prod_lo_ff;
   logic [HI_P_BITS-1:0] prod_hi_ff;
   logic                 neg_ff;
   logic [P_BITS-1:0]    p_full;
   logic [P_BITS-1:0]    p_sat;
   logic [VB-1:0]        vis_val;
   logic [VB-1:0]        vis_re_stage_ff;
   logic [VB-1:0]        vis_im_stage_ff;
   dpcc_pkg::rsp_type    rsp_data_ff;

   assign ar[0] = req_data.a_pol0_re;
   assign ai[0] = req_data.a_pol0_im;
   assign ar[1] = req_data.a_pol1_re;
   assign ai[1] = req_data.a_pol1_im;
   assign br[0] = req_data.b_pol0_re;
   assign bi[0] = req_data.b_pol0_im;
   assign br[1] = req_data.b_pol1_re;
   assign bi[1] = req_data.b_pol1_im;

   // a * conj(b): re = ar*br + ai*bi, im = ai*br - ar*bi
   for (genvar gp = 0; gp < 2; gp++) begin : g_pa
      for (genvar gq = 0; gq < 2; gq++) begin : g_pb
         logic signed [2*SB-1:0] m_rr, m_ii, m_ir, m_ri;
         assign m_rr = ar[gp] * br[gq];
         assign m_ii = ai[gp] * bi[gq];
         assign m_ir = ai[gp] * br[gq];
         assign m_ri = ar[gp] * bi[gq];
         assign prod_re[gp*2+gq] = {m_rr[2*SB-1], m_rr} + {m_ii[2*SB-1], m_ii};
         assign prod_im[gp*2+gq] = {m_ir[2*SB-1], m_ir} - {m_ri[2*SB-1], m_ri};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) p1_valid_ff <= 1'b0;
      else p1_valid_ff <= cmd.mac_en;
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_en) begin
         p1_re_ff <= prod_re;
         p1_im_ff <= prod_im;
      end
   end

   for (genvar gk = 0; gk < 4; gk++) begin : g_acc
      always_ff @(posedge clock) begin
         if (reset || cmd.clear) begin
            acc_re_ff[gk] <= '0;
            acc_im_ff[gk] <= '0;
         end else if (p1_valid_ff) begin
            acc_re_ff[gk] <= sat_add(acc_re_ff[gk], p1_re_ff[gk]);
            acc_im_ff[gk] <= sat_add(acc_im_ff[gk], p1_im_ff[gk]);
         end
      end
   end

   // magnitude times norm in two halves, then recombine and clamp
   assign acc_sel = cmd.sel[0] ? acc_im_ff[cmd.sel[2:1]] : acc_re_ff[cmd.sel[2:1]];
   assign neg     = acc_sel[ACC_BITS-1];
   assign mag     = neg ? (~acc_sel + 1'b1) : acc_sel;

   always_ff @(posedge clock) begin
      if (cmd.mul_lo) begin
         prod_lo_ff <= mag[HALF-1:0] * norm_scale;
         neg_ff     <= neg;
      end
      if (cmd.mul_hi) prod_hi_ff <= mag[ACC_BITS-1:HALF] * norm_scale;
   end

   always_comb begin
      p_full = {prod_hi_ff, {HALF{1'b0}}} + {{HI_BITS{1'b0}}, prod_lo_ff};
      if (neg_ff) p_sat = (p_full > LIM_NEG) ? LIM_NEG : p_full;
      else p_sat = (p_full > LIM_POS) ? LIM_POS : p_full;
      vis_val = neg_ff ? (~p_sat[VB-1:0] + 1'b1) : p_sat[VB-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         if (cmd.sel[0] == 1'b0) vis_re_stage_ff <= vis_val;
         else vis_im_stage_ff <= vis_val;
      end
      if (cmd.load) begin
         rsp_data_ff.pol_pair <= cmd.sel[2:1];
         rsp_data_ff.vis_re   <= vis_re_stage_ff;
         rsp_data_ff.vis_im   <= vis_im_stage_ff;
         rsp_data_ff.run_end  <= (cmd.sel[2:1] == dpcc_pkg::PAIR_LAST);
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ===== hdl/dual_pol_cross_correlator_core.sv =====
// Dual-polarisation cross-correlator for one baseline: top level.
// Holds the norm_scale register and joins dpcc_ctrl and dpcc_datapath.
// Depends on dpcc_pkg, dpcc_ctrl and dpcc_datapath.
//
// Usage:
//   req_*  : one time sample of both antennas, both polarisations, per
//            transfer. Samples are taken one per cycle while req_stall is low.
//   rsp_*  : four visibilities per interval, pol pairs 00, 01, 10, 11;
//            run_end marks the fourth.
//   APB    : norm_scale (Q16.16) at address 0, written while the block is idle.
// Sequence: a sample marked final_sample goes through a product stage and
//   the accumulators, then each visibility component is scaled on the one
//   shared split-multiply scaler (two half-width partial products, formed in
//   turn, and a recombine/clamp). req_stall is high from the final
//   transfer until the fourth result has been loaded.
// A stalled result holds in the output register; the sequencer waits
//   before loading the next one. After the fourth is loaded the
//   accumulators are cleared and samples are taken again.
// Reset clears the accumulators and sets norm_scale to 1.0.
module dual_pol_cross_correlator_core #(
   parameter int ACC_BITS = dpcc_pkg::ACC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  dpcc_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output dpcc_pkg::rsp_type                  rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [dpcc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   localparam logic REG_NORM_SCALE = 1'b0;

   logic [dpcc_pkg::NORM_BITS-1:0] norm_ff;
   logic                           csr_write;
   dpcc_pkg::cmd_type              cmd;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_NORM_SCALE);
   assign prdata    = (paddr[2] == REG_NORM_SCALE) ? norm_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) norm_ff <= dpcc_pkg::NORM_RESET;
      else if (csr_write) norm_ff <= pwdata;
   end

   dpcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_final (req_data.final_sample),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   dpcc_datapath #(
      .ACC_BITS (ACC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .norm_scale (norm_ff),
      .rsp_data   (rsp_data)
   );

endmodule
